// ===== sv/sefr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sefr_pkg
// Types and constants shared by the STX/ETX frame receiver core.
// ----------------------------------------------------------------------------
package sefr_pkg;

	// Frame store geometry and the overflow limit on the write index.
	localparam int STORE_DEPTH  = 64;
	localparam int IDX_W        = $clog2(STORE_DEPTH);
	localparam int COUNT_W      = 7;
	localparam int BUFFER_LIMIT = 63;

	// Field widths.
	localparam int BYTE_W  = 8;
	localparam int OP_W    = 2;
	localparam int STATE_W = 2;

	// Stream word widths.
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRANSPARENT = 2'd0,
		CFG_START_CODE  = 2'd1,
		CFG_END_CODE    = 2'd2
	} cfg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_BYTE    = 2'd0,
		OP_READ    = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [STATE_W-1:0] {
		ST_IDLE  = 2'd0,
		ST_RECV  = 2'd1,
		ST_READY = 2'd2
	} rx_state_t;

	// Escape sequence characters in order.
	localparam logic [BYTE_W-1:0] ESC_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] ESC_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] ESC_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] ESC_QUERY = 8'h3F;

	function automatic logic [BYTE_W-1:0] esc_char(input logic [1:0] step);
		logic [BYTE_W-1:0] c;
		unique case (step)
			2'd0:    c = ESC_PLUS;
			2'd1:    c = ESC_MINUS;
			2'd2:    c = ESC_HASH;
			default: c = ESC_QUERY;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/stx_etx_frame_receiver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver_core
// Collects received bytes framed by start and end codes into a 64-entry
// byte store, serves reads from it and echoes bytes in transparent mode.
// ----------------------------------------------------------------------------
// Each result is registered in the output register, which frees in the cycle
// it is taken, so no bubble appears. Throughput: one item per cycle when the
// output is not stalled; the store has one write and one registered read
// port, so every item touches the memory at most once on each.
// Reset: arst_n clears control state, configuration and output valid; the
// store and output payload are not reset, entries undefined until written.
// ----------------------------------------------------------------------------
module stx_etx_frame_receiver_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port
	input  logic                               cfg_we,
	input  logic [sefr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sefr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// Input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata: rx_byte[7:0], read_index[13:8], zero fill [15:14]
	input  logic [sefr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// tuser: operation[1:0]
	input  logic [sefr_pkg::OP_W-1:0]          s_axis_tuser,
	// Output stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// tdata: rx_state[1:0], frame_size[8:2], read_data[16:9], echo_valid[17],
	//        echo_byte[25:18], escape_seen[26], zero fill [31:27]
	output logic [sefr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// tlast: frame_done
	output logic                               m_axis_tlast
);
	import sefr_pkg::*;

	// Configuration registers.
	logic              transparent_q;
	logic [BYTE_W-1:0] start_code_q;
	logic [BYTE_W-1:0] end_code_q;

	// Control state.
	rx_state_t          state_q, state_d;
	logic [IDX_W-1:0]   widx_q, widx_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [1:0]         esc_step_q, esc_step_d;
	logic               esc_flag_q, esc_flag_d;

	// Byte store: entry 0 lives in its own register because a restart inside
	// a frame writes both the current entry and entry 0 in the same cycle.
	logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
	logic [BYTE_W-1:0] entry0_q;

	// Output register.
	logic               out_valid_q;
	rx_state_t          state_s1;
	logic [COUNT_W-1:0] count_s1;
	logic               done_s1;
	logic               is_read_s1;
	logic [BYTE_W-1:0]  rdata_s1;
	logic               evalid_s1;
	logic [BYTE_W-1:0]  ebyte_s1;
	logic               esc_flag_s1;

	// Decoded input fields.
	op_t               op;
	logic [BYTE_W-1:0] rx_byte;
	logic [IDX_W-1:0]  read_index;
	logic              accept;
	logic              framed_byte;
	logic              mem_we;
	logic              entry0_we;
	logic              done_d;

	assign op         = op_t'(s_axis_tuser);
	assign rx_byte    = s_axis_tdata[BYTE_W-1:0];
	assign read_index = s_axis_tdata[BYTE_W +: IDX_W];

	// A new item enters whenever the output register is empty or draining.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign framed_byte   = (op == OP_BYTE) && !transparent_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transparent_q <= 1'b0;
			start_code_q  <= 8'd2;
			end_code_q    <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRANSPARENT: transparent_q <= cfg_wdata[0];
				CFG_START_CODE:  start_code_q  <= cfg_wdata;
				CFG_END_CODE:    end_code_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Next receive state.
	always_comb begin
		state_d = state_q;
		if (framed_byte) begin
			unique case (state_q)
				ST_IDLE: begin
					if (rx_byte == start_code_q) state_d = ST_RECV;
				end
				ST_RECV: begin
					if (rx_byte == end_code_q) state_d = ST_READY;
					else if (rx_byte == start_code_q) state_d = ST_RECV;
					else if (int'(widx_q) >= BUFFER_LIMIT) state_d = ST_IDLE;
				end
				default: ;
			endcase
		end else if (op == OP_RELEASE && state_q == ST_READY) begin
			state_d = ST_IDLE;
		end
	end

	// Index, count and store write enables.
	always_comb begin
		widx_d    = widx_q;
		count_d   = count_q;
		done_d    = 1'b0;
		mem_we    = 1'b0;
		entry0_we = 1'b0;
		if (framed_byte) begin
			// Every framed byte lands at the write index first.
			mem_we    = (widx_q != '0);
			entry0_we = (widx_q == '0);
			unique case (state_q)
				ST_IDLE: begin
					if (rx_byte == start_code_q) begin
						widx_d  = IDX_W'(1);
						count_d = COUNT_W'(1);
					end
				end
				ST_RECV: begin
					priority if (rx_byte == end_code_q) begin
						widx_d  = '0;
						count_d = count_q + COUNT_W'(1);
						done_d  = 1'b1;
					end else if (rx_byte == start_code_q) begin
						entry0_we = 1'b1;
						widx_d    = IDX_W'(1);
						count_d   = COUNT_W'(1);
					end else if (int'(widx_q) < BUFFER_LIMIT) begin
						widx_d  = widx_q + IDX_W'(1);
						count_d = count_q + COUNT_W'(1);
					end else begin
						widx_d  = '0;
						count_d = '0;
					end
				end
				default: ;
			endcase
		end else if (op == OP_RELEASE && state_q == ST_READY) begin
			widx_d  = '0;
			count_d = '0;
		end
	end

	// Escape sequence tracker, transparent mode only.
	always_comb begin
		esc_step_d = esc_step_q;
		esc_flag_d = esc_flag_q;
		if (op == OP_BYTE && transparent_q) begin
			if (rx_byte == esc_char(esc_step_q)) begin
				if (esc_step_q == 2'd3) esc_flag_d = 1'b1;
				else esc_step_d = esc_step_q + 2'd1;
			end else begin
				esc_step_d = 2'd0;
			end
		end
	end

	// Control state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			widx_q     <= '0;
			count_q    <= '0;
			esc_step_q <= 2'd0;
			esc_flag_q <= 1'b0;
		end else if (accept) begin
			state_q    <= state_d;
			widx_q     <= widx_d;
			count_q    <= count_d;
			esc_step_q <= esc_step_d;
			esc_flag_q <= esc_flag_d;
		end
	end

	// Store write port.
	always_ff @(posedge clk) begin
		if (accept && mem_we) store_mem[widx_q] <= rx_byte;
	end

	always_ff @(posedge clk) begin
		if (accept && entry0_we) entry0_q <= rx_byte;
	end

	// Store read port, registered into the output stage.
	always_ff @(posedge clk) begin
		if (accept && op == OP_READ) begin
			if (read_index == '0) rdata_s1 <= entry0_q;
			else rdata_s1 <= store_mem[read_index];
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			state_s1    <= state_d;
			count_s1    <= count_d;
			done_s1     <= done_d;
			is_read_s1  <= (op == OP_READ);
			evalid_s1   <= (op == OP_BYTE) && transparent_q;
			ebyte_s1    <= ((op == OP_BYTE) && transparent_q) ? rx_byte : '0;
			esc_flag_s1 <= esc_flag_d;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = done_s1;
	assign m_axis_tdata  = {
		5'd0,
		esc_flag_s1,
		ebyte_s1,
		evalid_s1,
		(is_read_s1 ? rdata_s1 : {BYTE_W{1'b0}}),
		count_s1,
		state_s1
	};

	// Idle means an empty frame with the write pointer home.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (widx_q == '0 && count_q == '0))
		else $error("idle state with non-zero index or count");

	// While receiving, the count tracks the write pointer and never uses entry 0.
	a_recv_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RECV) |-> (widx_q != '0 && COUNT_W'(widx_q) == count_q))
		else $error("receive index and count out of step");

	// A completed frame is always reported in the ready state.
	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[1:0] == ST_READY))
		else $error("frame completion outside ready state");

	// A frame completion moves the receiver to ready at the next edge.
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && done_d) |=> (state_q == ST_READY))
		else $error("end code did not make the frame ready");

endmodule
